@@ hw/rtl/bru_pkg.sv @@
// Package for the bitmap to RGBA unpacker.
// Holds configuration codes, pixel mode codes, reset values and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package bru_pkg;

  localparam int unsigned MaxWidthDef     = 4096;
  localparam int unsigned MaxHeightDef    = 4096;
  localparam int unsigned PaletteDepthDef = 256;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] CfgPixelMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRowPitch    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPaletteSize = 3'd4;

  localparam logic [1:0] ModeIdx8   = 2'd0;
  localparam logic [1:0] ModeBgr24  = 2'd1;
  localparam logic [1:0] ModeBgra32 = 2'd2;

  localparam logic [1:0]  PixelModeRst   = ModeBgra32;
  localparam logic [12:0] ImageWidthRst  = 13'd1;
  localparam logic [12:0] ImageHeightRst = 13'd1;
  localparam logic [14:0] RowPitchRst    = 15'd4;
  localparam logic [8:0]  PaletteSizeRst = 9'd256;

  localparam logic [7:0] OpaqueAlpha = 8'd255;

  typedef struct packed {
    logic [1:0]  pixel_mode;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [14:0] row_pitch;
    logic [8:0]  palette_size;
  } cfg_t;

  typedef struct packed {
    logic        wr_en;
    logic [7:0]  wr_idx;
    logic [23:0] wr_data;
    logic        rd_en;
    logic [7:0]  rd_idx;
  } pal_cmd_t;

  typedef struct packed {
    logic       use_pal;
    logic       in_range;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
  } pix_req_t;

endpackage

@@ hw/rtl/bru_if.sv @@
// Stream interfaces of the bitmap to RGBA unpacker.
// Input byte and palette write channel, and RGBA pixel output channel.
// No dependencies.
`timescale 1ns / 1ps

interface bru_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic [7:0] palette_index;
  logic [7:0] palette_red;
  logic [7:0] palette_green;
  logic [7:0] palette_blue;

  modport source (output valid, req_type, data_byte, palette_index, palette_red,
                  palette_green, palette_blue, input ready);
  modport sink (input valid, req_type, data_byte, palette_index, palette_red,
                palette_green, palette_blue, output ready);
endinterface

interface bru_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_pixel;

  modport source (output valid, red, green, blue, alpha, last_pixel, input ready);
  modport sink (input valid, red, green, blue, alpha, last_pixel, output ready);
endinterface

@@ hw/rtl/bru_cfg_regs.sv @@
// Configuration register bank of the bitmap to RGBA unpacker.
// Depends on bru_pkg.
`timescale 1ns / 1ps

module bru_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bru_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bru_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output bru_pkg::cfg_t                 cfg_o
);

  bru_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bru_pkg::CfgPixelMode:   cfg_d.pixel_mode   = cfg_wdata_i[1:0];
        bru_pkg::CfgImageWidth:  cfg_d.image_width  = cfg_wdata_i[12:0];
        bru_pkg::CfgImageHeight: cfg_d.image_height = cfg_wdata_i[12:0];
        bru_pkg::CfgRowPitch:    cfg_d.row_pitch    = cfg_wdata_i[14:0];
        bru_pkg::CfgPaletteSize: cfg_d.palette_size = cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode   <= bru_pkg::PixelModeRst;
      cfg_q.image_width  <= bru_pkg::ImageWidthRst;
      cfg_q.image_height <= bru_pkg::ImageHeightRst;
      cfg_q.row_pitch    <= bru_pkg::RowPitchRst;
      cfg_q.palette_size <= bru_pkg::PaletteSizeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/bru_palette_ram.sv @@
// Palette memory: one write port and one read port with registered read data.
// Depends on bru_pkg.
`timescale 1ns / 1ps

module bru_palette_ram #(
  parameter int unsigned PALETTE_DEPTH = bru_pkg::PaletteDepthDef
) (
  input  logic              clk_i,
  input  bru_pkg::pal_cmd_t cmd_i,
  output logic [23:0]       rd_data_o
);

  localparam int unsigned AddrW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0] mem_q [PALETTE_DEPTH];
  logic [23:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_idx[AddrW-1:0]] <= cmd_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[cmd_i.rd_idx[AddrW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/bru_unpack_ctrl.sv @@
// Byte stream control: pixel, row and image counters and the partial pixel.
// Issues palette reads and writes and hands completed pixels on. Depends on bru_pkg.
`timescale 1ns / 1ps

module bru_unpack_ctrl #(
  parameter int unsigned MAX_WIDTH     = bru_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT    = bru_pkg::MaxHeightDef,
  parameter int unsigned PALETTE_DEPTH = bru_pkg::PaletteDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bru_pkg::cfg_t     cfg_i,
  input  logic              acc_i,
  input  logic              req_type_i,
  input  logic [7:0]        data_byte_i,
  input  logic [7:0]        palette_index_i,
  input  logic [7:0]        palette_red_i,
  input  logic [7:0]        palette_green_i,
  input  logic [7:0]        palette_blue_i,
  output bru_pkg::pal_cmd_t pal_cmd_o,
  output logic              res_valid_o,
  output bru_pkg::pix_req_t res_o
);

  localparam int unsigned WidthW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HeightW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PixW    = $clog2(4 * MAX_WIDTH + 1);
  localparam int unsigned RowW    = (PixW > 15) ? PixW : 15;
  localparam logic [8:0]  PalDepth = 9'(PALETTE_DEPTH);

  logic [1:0]         bip_q, bip_d;
  logic [23:0]        partial_q, partial_d;
  logic [RowW-1:0]    brow_q, brow_d;
  logic [WidthW-1:0]  col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;

  logic [WidthW-1:0]  width;
  logic [HeightW-1:0] height;
  logic [2:0]         bpp;
  logic [RowW-1:0]    pix_bytes;
  logic [RowW-1:0]    row_len;
  logic [RowW-1:0]    brow_inc;
  logic               pix_byte;
  logic               active;
  logic               complete;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      width = WidthW'(1);
    end else if (32'(cfg_i.image_width) > MAX_WIDTH) begin
      width = WidthW'(MAX_WIDTH);
    end else begin
      width = WidthW'(cfg_i.image_width);
    end
    if (cfg_i.image_height == '0) begin
      height = HeightW'(1);
    end else if (32'(cfg_i.image_height) > MAX_HEIGHT) begin
      height = HeightW'(MAX_HEIGHT);
    end else begin
      height = HeightW'(cfg_i.image_height);
    end
    unique case (cfg_i.pixel_mode)
      bru_pkg::ModeIdx8: begin
        bpp       = 3'd1;
        pix_bytes = RowW'(width);
      end
      bru_pkg::ModeBgr24: begin
        bpp       = 3'd3;
        pix_bytes = RowW'(width) + (RowW'(width) << 1);
      end
      default: begin
        bpp       = 3'd4;
        pix_bytes = RowW'(width) << 2;
      end
    endcase
    row_len = (RowW'(cfg_i.row_pitch) > pix_bytes) ? RowW'(cfg_i.row_pitch) : pix_bytes;
  end

  assign pix_byte = acc_i && !req_type_i;
  assign active   = col_q < width;
  assign complete = active && (({1'b0, bip_q} + 3'd1) >= bpp);
  assign brow_inc = brow_q + RowW'(1);

  always_comb begin
    bip_d     = bip_q;
    partial_d = partial_q;
    brow_d    = brow_q;
    col_d     = col_q;
    row_d     = row_q;
    if (pix_byte) begin
      if (complete) begin
        bip_d     = 2'd0;
        partial_d = '0;
        col_d     = col_q + WidthW'(1);
      end else if (active) begin
        if (bip_q != 2'd3) begin
          partial_d = partial_q | (24'(data_byte_i) << (5'(bip_q) << 3));
        end
        bip_d = bip_q + 2'd1;
      end
      brow_d = brow_inc;
      if (brow_inc >= row_len) begin
        brow_d    = '0;
        col_d     = '0;
        bip_d     = 2'd0;
        partial_d = '0;
        if (({1'b0, row_q} + (HeightW + 1)'(1)) >= {1'b0, height}) begin
          row_d = '0;
        end else begin
          row_d = row_q + HeightW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bip_q     <= 2'd0;
      partial_q <= '0;
      brow_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      bip_q     <= bip_d;
      partial_q <= partial_d;
      brow_q    <= brow_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

  always_comb begin
    res_o.use_pal  = 1'b0;
    res_o.in_range = ({1'b0, data_byte_i} < cfg_i.palette_size) &&
                     ({1'b0, data_byte_i} < PalDepth);
    res_o.red      = partial_q[23:16];
    res_o.green    = partial_q[15:8];
    res_o.blue     = partial_q[7:0];
    res_o.alpha    = data_byte_i;
    unique case (cfg_i.pixel_mode)
      bru_pkg::ModeIdx8: begin
        res_o.use_pal = 1'b1;
        res_o.alpha   = bru_pkg::OpaqueAlpha;
      end
      bru_pkg::ModeBgr24: begin
        res_o.red   = data_byte_i;
        res_o.alpha = bru_pkg::OpaqueAlpha;
      end
      default: ;
    endcase
    res_o.last_pixel = (({1'b0, col_q} + (WidthW + 1)'(1)) == {1'b0, width}) &&
                       (({1'b0, row_q} + (HeightW + 1)'(1)) >= {1'b0, height});
  end

  assign res_valid_o = pix_byte && complete;

  assign pal_cmd_o.wr_en   = acc_i && req_type_i && ({1'b0, palette_index_i} < PalDepth);
  assign pal_cmd_o.wr_idx  = palette_index_i;
  assign pal_cmd_o.wr_data = {palette_red_i, palette_green_i, palette_blue_i};
  assign pal_cmd_o.rd_en   = pix_byte && complete && (cfg_i.pixel_mode == bru_pkg::ModeIdx8);
  assign pal_cmd_o.rd_idx  = data_byte_i;

endmodule

@@ hw/rtl/bru_out_stage.sv @@
// Result pipeline: palette read stage and output register with backpressure.
// Depends on bru_pkg and bru_out_if.
`timescale 1ns / 1ps

module bru_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  bru_pkg::pix_req_t res_i,
  input  logic [23:0]       rd_data_i,
  output logic              in_ready_o,
  bru_out_if.source         out_chan_o
);

  logic              s1_valid_q, s1_valid_d;
  bru_pkg::pix_req_t s1_q;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        red_q, green_q, blue_q, alpha_q;
  logic              last_q;
  logic              s2_free;
  logic              s1_move;

  assign s2_free    = !out_valid_q || out_chan_o.ready;
  assign in_ready_o = !s1_valid_q || s2_free;
  assign s1_move    = s1_valid_q && s2_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = res_valid_i;
    end
    out_valid_d = out_valid_q;
    if (s2_free) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && res_valid_i) begin
      s1_q <= res_i;
    end
    if (s1_move) begin
      alpha_q <= s1_q.alpha;
      last_q  <= s1_q.last_pixel;
      if (s1_q.use_pal) begin
        red_q   <= s1_q.in_range ? rd_data_i[23:16] : 8'd0;
        green_q <= s1_q.in_range ? rd_data_i[15:8] : 8'd0;
        blue_q  <= s1_q.in_range ? rd_data_i[7:0] : 8'd0;
      end else begin
        red_q   <= s1_q.red;
        green_q <= s1_q.green;
        blue_q  <= s1_q.blue;
      end
    end
  end

  assign out_chan_o.valid      = out_valid_q;
  assign out_chan_o.red        = red_q;
  assign out_chan_o.green      = green_q;
  assign out_chan_o.blue       = blue_q;
  assign out_chan_o.alpha      = alpha_q;
  assign out_chan_o.last_pixel = last_q;

`ifndef ASSERT_OFF
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_free |=> s1_valid_q && $stable(s1_q))
    else $error("pending pixel changed while the output was stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_free |-> !in_ready_o)
    else $error("input accepted while both result stages were full");

  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("pixel lost between the read stage and the output register");
`endif

endmodule

@@ hw/rtl/bitmap_to_rgba_unpacker_top.sv @@
// Bitmap to RGBA unpacker: one source byte or palette write per cycle in and
// one RGBA pixel out per completed source pixel, via the palette read stage
// and output register, while out_chan_o is not stalled; one palette read port.
// Reset clears the counters and returns the configuration registers to their
// defaults; the palette has no reset and no clearing pass, and an entry must be
// written before it is used.
`timescale 1ns / 1ps

module bitmap_to_rgba_unpacker_top #(
  parameter int unsigned MAX_WIDTH     = bru_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT    = bru_pkg::MaxHeightDef,
  parameter int unsigned PALETTE_DEPTH = bru_pkg::PaletteDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bru_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bru_pkg::CfgDataW-1:0] cfg_wdata_i,
  bru_in_if.sink                       in_chan_i,
  bru_out_if.source                    out_chan_o
);

  bru_pkg::cfg_t     cfg;
  bru_pkg::pal_cmd_t pal_cmd;
  bru_pkg::pix_req_t res;
  logic              res_valid;
  logic              in_ready;
  logic              in_acc;
  logic [23:0]       rd_data;

  assign in_chan_i.ready = in_ready;
  assign in_acc          = in_chan_i.valid && in_ready;

  bru_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bru_unpack_ctrl #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .acc_i           (in_acc),
    .req_type_i      (in_chan_i.req_type),
    .data_byte_i     (in_chan_i.data_byte),
    .palette_index_i (in_chan_i.palette_index),
    .palette_red_i   (in_chan_i.palette_red),
    .palette_green_i (in_chan_i.palette_green),
    .palette_blue_i  (in_chan_i.palette_blue),
    .pal_cmd_o       (pal_cmd),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  bru_palette_ram #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_pal (
    .clk_i     (clk_i),
    .cmd_i     (pal_cmd),
    .rd_data_o (rd_data)
  );

  bru_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .rd_data_i   (rd_data),
    .in_ready_o  (in_ready),
    .out_chan_o  (out_chan_o)
  );

endmodule
